// ===== rtl/vll_pkg.sv =====
// Shared constants, register codes and the point light level function.
package vll_pkg;

  localparam int COLUMN_SIDE = 16;
  localparam int LAYERS      = 128;
  localparam int MAX_LIGHTS  = 6;

  localparam int SIDE_W  = $clog2(COLUMN_SIDE);
  localparam int COL_W   = 2 * SIDE_W;
  localparam int COLUMNS = COLUMN_SIDE * COLUMN_SIDE;

  localparam int X_W   = 4;
  localparam int Y_W   = 7;
  localparam int Z_W   = 4;
  localparam int LVL_W = 4;
  localparam int LIGHT_W = 48;
  localparam int CNT_W   = 3;

  // Squared distance widths (12.4 fixed point coordinates)
  localparam int DIFF_W = 17;
  localparam int SQ_W   = 31;
  localparam int D2_W   = 32;

  localparam logic [Y_W-1:0]   TOP_Y     = Y_W'(LAYERS - 1);
  localparam logic [LVL_W-1:0] LEVEL_MAX = 4'd15;
  localparam logic [LVL_W-1:0] LEVEL_MIN = 4'd1;
  localparam logic [CNT_W-1:0] LIGHTS_SAT = CNT_W'(MAX_LIGHTS);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LIGHT_COUNT,
    REG_LIGHT_0,
    REG_LIGHT_1,
    REG_LIGHT_2,
    REG_LIGHT_3,
    REG_LIGHT_4,
    REG_LIGHT_5
  } reg_idx_t;

  // Column record: seen bit over top height
  typedef struct packed {
    logic           seen;
    logic [Y_W-1:0] top;
  } col_rec_t;

  // Largest k with d2 <= ((15 - k) * 16)^2, or 0 when the light is too far
  function automatic logic [LVL_W-1:0] point_level(input logic [D2_W-1:0] d2);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int r = 14; r >= 0; r--) begin
      if (d2 <= D2_W'(r * r * 256)) begin
        lvl = LVL_W'(15 - r);
      end
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/voxel_light_level_top.sv =====
// Voxel light level pipeline: column tracking, sky light and point lights.
// Each item passes through the stage 1, stage 2 and output registers in order.
// Throughput: one item per cycle unless out_tready stalls; the column store is read
// on accept, written back by stage 1, bypassed for back-to-back same-column items.
// Reset (synchronous, rst_n low): pipeline empty, light_count and light positions zero.
// Column store contents are not cleared; a column is defined once its top layer arrives.
module voxel_light_level_top
  import vll_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pos_x[3:0], pos_y[10:4], pos_z[14:11], solid[15]
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_x[3:0], out_y[10:4], out_z[14:11],
                                  // light_level[18:15], zero[23:19]
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers
  logic [CNT_W-1:0]   cnt_r;
  logic [LIGHT_W-1:0] light_r [MAX_LIGHTS];
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  // Handshake and stage control
  logic acc, out_ok, s2_adv, s2_ready, s1_adv, s1_ready;
  logic s1_v_r, s2_v_r, out_v_r;

  // Stage 1: item and column read
  logic [X_W-1:0] s1_x_r;
  logic [Y_W-1:0] s1_y_r;
  logic [Z_W-1:0] s1_z_r;
  logic           s1_solid_r;
  col_rec_t       rd_r, byp_data_r, cur, col_new;
  logic           byp_r;
  logic [COL_W-1:0] col_in, s1_col;
  col_rec_t       col_mem [COLUMNS];

  // Stage 1 results
  logic [LVL_W-1:0] sky_nxt;
  logic [Y_W-1:0]   top_diff;
  logic [Y_W-2:0]   drop;
  logic [SQ_W-1:0]  sq_nxt [MAX_LIGHTS][3];
  logic [MAX_LIGHTS-1:0] act_nxt;
  logic [CNT_W-1:0] n_act;

  // Stage 2 registers
  logic [X_W-1:0]   s2_x_r;
  logic [Y_W-1:0]   s2_y_r;
  logic [Z_W-1:0]   s2_z_r;
  logic [LVL_W-1:0] s2_sky_r;
  logic [SQ_W-1:0]  sq_r [MAX_LIGHTS][3];
  logic [MAX_LIGHTS-1:0] s2_act_r;
  logic [LVL_W-1:0] lvl_nxt;

  // Output registers
  logic [X_W-1:0]   out_x_r;
  logic [Y_W-1:0]   out_y_r;
  logic [Z_W-1:0]   out_z_r;
  logic [LVL_W-1:0] out_lvl_r;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < MAX_LIGHTS; i++) begin
        light_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LIGHT_COUNT: cnt_r      <= cfg_pwdata[CNT_W-1:0];
        REG_LIGHT_0:     light_r[0] <= cfg_pwdata[LIGHT_W-1:0];
        REG_LIGHT_1:     light_r[1] <= cfg_pwdata[LIGHT_W-1:0];
        REG_LIGHT_2:     light_r[2] <= cfg_pwdata[LIGHT_W-1:0];
        REG_LIGHT_3:     light_r[3] <= cfg_pwdata[LIGHT_W-1:0];
        REG_LIGHT_4:     light_r[4] <= cfg_pwdata[LIGHT_W-1:0];
        REG_LIGHT_5:     light_r[5] <= cfg_pwdata[LIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LIGHT_COUNT: cfg_prdata = 64'(cnt_r);
      REG_LIGHT_0:     cfg_prdata = 64'(light_r[0]);
      REG_LIGHT_1:     cfg_prdata = 64'(light_r[1]);
      REG_LIGHT_2:     cfg_prdata = 64'(light_r[2]);
      REG_LIGHT_3:     cfg_prdata = 64'(light_r[3]);
      REG_LIGHT_4:     cfg_prdata = 64'(light_r[4]);
      REG_LIGHT_5:     cfg_prdata = 64'(light_r[5]);
      default:         cfg_prdata = '0;
    endcase
  end

  // Stage flow: each stage moves when the next one has room
  assign out_ok   = !out_v_r || out_tready;
  assign s2_adv   = s2_v_r && out_ok;
  assign s2_ready = !s2_v_r || out_ok;
  assign s1_adv   = s1_v_r && s2_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;
  assign acc      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Column index of the incoming item and of the item in stage 1
  assign col_in = {in_tdata[SIDE_W-1:0], in_tdata[11 +: SIDE_W]};
  assign s1_col = {s1_x_r[SIDE_W-1:0], s1_z_r[SIDE_W-1:0]};

  // Column store: write back from stage 1, read for the entering item
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      col_mem[s1_col] <= col_new;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= col_mem[col_in];
    end
  end

  // Capture the item and forward a same-cycle write to the same column
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x_r     <= in_tdata[3:0];
      s1_y_r     <= in_tdata[10:4];
      s1_z_r     <= in_tdata[14:11];
      s1_solid_r <= in_tdata[15];
      byp_data_r <= col_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (acc) begin
      byp_r <= s1_adv && (s1_col == col_in);
    end
  end

  // Column update and sky light
  assign cur = byp_r ? byp_data_r : rd_r;

  always_comb begin
    col_new = cur;
    if (s1_y_r == TOP_Y) begin
      col_new.seen = s1_solid_r;
      col_new.top  = s1_y_r;
    end else if (s1_solid_r && !cur.seen) begin
      col_new.seen = 1'b1;
      col_new.top  = s1_y_r;
    end
  end

  assign top_diff = col_new.top - s1_y_r;
  assign drop     = top_diff[Y_W-1:1];

  always_comb begin
    if (!col_new.seen || (col_new.top <= s1_y_r)) begin
      sky_nxt = LEVEL_MAX;
    end else if (drop >= (Y_W-1)'(14)) begin
      sky_nxt = LEVEL_MIN;
    end else begin
      sky_nxt = LEVEL_MAX - drop[LVL_W-1:0];
    end
  end

  // Squared offsets of each light from the voxel, in 1/16 voxel units
  assign n_act = (cnt_r > LIGHTS_SAT) ? LIGHTS_SAT : cnt_r;

  always_comb begin
    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic signed [2*DIFF_W-1:0] px, py, pz;
    for (int i = 0; i < MAX_LIGHTS; i++) begin
      dx = $signed({light_r[i][47], light_r[i][47:32]})
         - $signed({(DIFF_W-X_W-4)'(0), s1_x_r, 4'b0});
      dy = $signed({light_r[i][31], light_r[i][31:16]})
         - $signed({(DIFF_W-Y_W-4)'(0), s1_y_r, 4'b0});
      dz = $signed({light_r[i][15], light_r[i][15:0]})
         - $signed({(DIFF_W-Z_W-4)'(0), s1_z_r, 4'b0});
      px = dx * dx;
      py = dy * dy;
      pz = dz * dz;
      sq_nxt[i][0] = px[SQ_W-1:0];
      sq_nxt[i][1] = py[SQ_W-1:0];
      sq_nxt[i][2] = pz[SQ_W-1:0];
      act_nxt[i]   = (CNT_W'(i) < n_act);
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_x_r   <= s1_x_r;
      s2_y_r   <= s1_y_r;
      s2_z_r   <= s1_z_r;
      s2_sky_r <= sky_nxt;
      s2_act_r <= act_nxt;
      for (int i = 0; i < MAX_LIGHTS; i++) begin
        for (int j = 0; j < 3; j++) begin
          sq_r[i][j] <= sq_nxt[i][j];
        end
      end
    end
  end

  // Sum the squared offsets, grade each active light and take the maximum with the sky light
  always_comb begin
    logic [D2_W-1:0]  d2;
    logic [LVL_W-1:0] pl;
    lvl_nxt = s2_sky_r;
    for (int i = 0; i < MAX_LIGHTS; i++) begin
      d2 = D2_W'(sq_r[i][0]) + D2_W'(sq_r[i][1]) + D2_W'(sq_r[i][2]);
      pl = point_level(d2);
      if (s2_act_r[i] && (pl > lvl_nxt)) begin
        lvl_nxt = pl;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_x_r   <= s2_x_r;
      out_y_r   <= s2_y_r;
      out_z_r   <= s2_z_r;
      out_lvl_r <= lvl_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_lvl_r, out_z_r, out_y_r, out_x_r};

`ifndef NO_ASSERTIONS
  // A delivered light level is never zero
  a_level_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_lvl_r != 4'd0))
    else $error("light level zero on output");

  // A top layer voxel always sees full sky light
  a_top_full_sky: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && (s2_y_r == TOP_Y)) |-> (s2_sky_r == LEVEL_MAX))
    else $error("top layer voxel without full sky light");

  // A stalled stage 2 item holds its content
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_adv) |=> (s2_v_r && $stable(s2_sky_r) && $stable(s2_y_r)))
    else $error("stage 2 item changed while stalled");

  // Bypass is flagged for an item that follows one of the same column
  a_bypass_col: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && s1_adv && (s1_col == col_in)) |=> byp_r)
    else $error("same column write not forwarded");
`endif

endmodule
